FILE: hw/rtl/hpt_pkg.sv
package hpt_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int NUM_REGS        = 8;
    localparam int ADDR_W          = 6;
    localparam int LANES           = 3;
    // quotient bits kept before clamping (magnitude up to 2^33)
    localparam int QBITS           = 33;
    // width of |S| << FRAC_BITS, independent of FRAC_BITS
    localparam int NUM_W           = 66;

    // register indexes
    localparam logic [2:0] REG_COL0_R01   = 3'd0;
    localparam logic [2:0] REG_COL1_R01   = 3'd2;
    localparam logic [2:0] REG_COL2_R23   = 3'd5;
    localparam logic [2:0] REG_TRANSL_R23 = 3'd7;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [31:0] result_x;
        logic signed [31:0] result_y;
        logic signed [31:0] result_z;
        logic               divided;
    } result_t;

endpackage

FILE: hw/rtl/hpt_queue.sv
module hpt_queue
    import hpt_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         rd,
    output logic [W-1:0] rdata,
    output logic         empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          do_wr, do_rd;

    assign full  = (cnt_reg == (AW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (wr && full) |-> !do_wr ##1 (cnt_reg <= (AW+1)'(DEPTH)))
        else $error("write into full queue");

    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count did not follow write");

endmodule

FILE: hw/rtl/hpt_front.sv
module hpt_front
    import hpt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int SW = 66 - FRAC_BITS,
    localparam int LW = SW + 33,
    localparam int PW = LANES * LW + SW + 1
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [NUM_REGS-1:0][63:0]      cfg,
    input  point_t                         point,
    input  logic                           push,
    output logic                           full,
    output logic                           q_wr,
    output logic [PW-1:0]                  q_wdata,
    input  logic                           q_full
);

    // stage 1: input, stage 2: products, stage 3: row sums, stage 4: classify
    point_t             pt_reg;
    logic signed [63:0] prod_reg [4][3];
    logic signed [63:0] prod_next [4][3];
    logic signed [SW-1:0] sum_reg [4];
    logic signed [SW-1:0] sum_next [4];
    logic [PW-1:0]      pay_reg, pay_next;
    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic               en;

    logic signed [31:0] vin [3];
    logic signed [31:0] cf [4][3];
    logic signed [31:0] tr [4];

    assign en      = !(v4_reg && q_full);
    assign full    = !en;
    assign q_wr    = v4_reg && !q_full;
    assign q_wdata = pay_reg;

    assign vin[0] = pt_reg.point_x;
    assign vin[1] = pt_reg.point_y;
    assign vin[2] = pt_reg.point_z;

    // column-major: register 2*col + row/2, row parity picks the half
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                cf[r][c] = cfg[c*2 + r/2][(r%2)*32 +: 32];
            end
            tr[r] = cfg[6 + r/2][(r%2)*32 +: 32];
        end
    end

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_next[r][c] = cf[r][c] * vin[c];
            end
        end
    end

    // floor of the exact product sum, then translation
    always_comb
    begin
        logic signed [65:0] acc;
        logic signed [65:0] shf;
        for (int r = 0; r < 4; r++)
        begin
            acc = 66'(prod_reg[r][0]) + 66'(prod_reg[r][1]) + 66'(prod_reg[r][2]);
            shf = acc >>> FRAC_BITS;
            sum_next[r] = shf[SW-1:0] + SW'(tr[r]);
        end
    end

    always_comb
    begin
        logic [SW-1:0]    s;
        logic [SW-1:0]    w;
        logic [SW-1:0]    mag;
        logic [SW-32:0]   upper;
        logic [31:0]      sat;
        pay_next = '0;
        w = sum_reg[3];
        for (int l = 0; l < LANES; l++)
        begin
            s     = sum_reg[l];
            mag   = s[SW-1] ? (~s + 1'b1) : s;
            upper = s[SW-1:31];
            if ((&upper) || !(|upper))
            begin
                sat = s[31:0];
            end
            else
            begin
                sat = s[SW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            pay_next[l*LW +: LW] = {sat, s[SW-1] ^ w[SW-1], mag};
        end
        pay_next[LANES*LW +: SW] = w[SW-1] ? (~w + 1'b1) : w;
        pay_next[LANES*LW + SW]  = |w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= push;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt_reg   <= point;
            prod_reg <= prod_next;
            sum_reg  <= sum_next;
            pay_reg  <= pay_next;
        end
    end

endmodule

FILE: hw/rtl/hpt_back.sv
module hpt_back
    import hpt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int SW = 66 - FRAC_BITS,
    localparam int LW = SW + 33,
    localparam int PW = LANES * LW + SW + 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  logic [PW-1:0] q_rdata,
    output logic          q_rd,
    output result_t       result,
    output logic          empty,
    input  logic          pop
);

    // stage 0 sets up, stages 1..QBITS each retire one quotient bit
    logic [SW:0]        rem_reg  [QBITS+1][LANES];
    logic [SW:0]        rem_next [QBITS+1][LANES];
    logic [QBITS-1:0]   nlo_reg  [QBITS+1][LANES];
    logic [QBITS-1:0]   nlo_next [QBITS+1][LANES];
    logic [QBITS-1:0]   quo_reg  [QBITS+1][LANES];
    logic [QBITS-1:0]   quo_next [QBITS+1][LANES];
    logic               ovf_reg  [QBITS+1][LANES];
    logic               ovf_next [LANES];
    logic               neg_reg  [QBITS+1][LANES];
    logic               neg_next [LANES];
    logic [31:0]        sat_reg  [QBITS+1][LANES];
    logic [31:0]        sat_next [LANES];
    logic [SW-1:0]      d_reg    [QBITS+1];
    logic               wnz_reg  [QBITS+1];
    logic               vld_reg  [QBITS+1];
    result_t            out_reg, out_next;
    logic               out_v_reg;
    logic               en;

    assign en     = !out_v_reg || pop;
    assign q_rd   = en && !q_empty;
    assign empty  = !out_v_reg;
    assign result = out_reg;

    always_comb
    begin
        logic [LW-1:0]    lane;
        logic [SW-1:0]    d;
        logic [NUM_W-1:0] num;
        logic [SW:0]      hi;
        logic [SW:0]      trial;
        logic             ge;
        d = q_rdata[LANES*LW +: SW];
        for (int l = 0; l < LANES; l++)
        begin
            lane        = q_rdata[l*LW +: LW];
            num         = {lane[SW-1:0], {FRAC_BITS{1'b0}}};
            hi          = (SW+1)'(num[NUM_W-1:QBITS]);
            ovf_next[l] = hi >= {1'b0, d};
            rem_next[0][l] = ovf_next[l] ? '0 : hi;
            nlo_next[0][l] = num[QBITS-1:0];
            quo_next[0][l] = '0;
            neg_next[l] = lane[SW];
            sat_next[l] = lane[SW+32:SW+1];
        end
        for (int k = 1; k <= QBITS; k++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                trial = {rem_reg[k-1][l][SW-1:0], nlo_reg[k-1][l][QBITS-1]};
                ge    = trial >= {1'b0, d_reg[k-1]};
                rem_next[k][l] = ge ? (trial - {1'b0, d_reg[k-1]}) : trial;
                nlo_next[k][l] = {nlo_reg[k-1][l][QBITS-2:0], 1'b0};
                quo_next[k][l] = {quo_reg[k-1][l][QBITS-2:0], ge};
            end
        end
    end

    // clamp magnitude to the signed 32-bit range and apply the sign; with w zero, pass the saturated sum
    always_comb
    begin
        logic [QBITS:0] m;
        logic [31:0]    v [LANES];
        for (int l = 0; l < LANES; l++)
        begin
            m = ovf_reg[QBITS][l] ? {1'b1, {QBITS{1'b0}}} : {1'b0, quo_reg[QBITS][l]};
            if (!wnz_reg[QBITS])
            begin
                v[l] = sat_reg[QBITS][l];
            end
            else if (neg_reg[QBITS][l])
            begin
                v[l] = (m > (QBITS+1)'(34'h0_8000_0000)) ? 32'h8000_0000 : (~m[31:0] + 1'b1);
            end
            else
            begin
                v[l] = (m > (QBITS+1)'(34'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF : m[31:0];
            end
        end
        out_next.result_x = v[0];
        out_next.result_y = v[1];
        out_next.result_z = v[2];
        out_next.divided  = wnz_reg[QBITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QBITS; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= !q_empty;
            for (int k = 1; k <= QBITS; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            out_v_reg <= vld_reg[QBITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0]   <= q_rdata[LANES*LW +: SW];
            wnz_reg[0] <= q_rdata[LANES*LW + SW];
            for (int l = 0; l < LANES; l++)
            begin
                ovf_reg[0][l] <= ovf_next[l];
                neg_reg[0][l] <= neg_next[l];
                sat_reg[0][l] <= sat_next[l];
            end
            for (int k = 1; k <= QBITS; k++)
            begin
                d_reg[k]   <= d_reg[k-1];
                wnz_reg[k] <= wnz_reg[k-1];
                for (int l = 0; l < LANES; l++)
                begin
                    ovf_reg[k][l] <= ovf_reg[k-1][l];
                    neg_reg[k][l] <= neg_reg[k-1][l];
                    sat_reg[k][l] <= sat_reg[k-1][l];
                end
            end
            for (int k = 0; k <= QBITS; k++)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[k][l] <= rem_next[k][l];
                    nlo_reg[k][l] <= nlo_next[k][l];
                    quo_reg[k][l] <= quo_next[k][l];
                end
            end
            out_reg <= out_next;
        end
    end

endmodule

FILE: hw/rtl/homogeneous_point_transform_unit.sv
// Channel   Ports                            Beat accepted when
// ------    -------------------------------  ----------------------------------
// point     point, push, full                push && !full
// result    result, empty, pop               pop && !empty
// config    psel penable pwrite paddr pwdata psel && penable && pwrite && pready
//
// One point per cycle sustained while results are popped; the path runs through
// 4 front stages, the queue, setup, 33 divide stages and the output register.
// The divider is a pipelined restoring divider, one quotient bit per stage.
// Reset clears all valid state and loads the identity matrix.
// A held result stalls only the back end; the front keeps filling the queue
// and raises full once the queue is full.
module homogeneous_point_transform_unit
    import hpt_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    // point channel
    input  point_t            point,
    input  logic              push,
    output logic              full,
    // result channel
    output result_t           result,
    output logic              empty,
    input  logic              pop,
    // APB config
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    localparam int SW = 66 - FRAC_BITS;
    localparam int LW = SW + 33;
    localparam int PW = LANES * LW + SW + 1;
    localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

    // matrix registers, 8 bytes apart
    logic [NUM_REGS-1:0][63:0] cfg_reg;
    logic [NUM_REGS-1:0][63:0] cfg_rst;
    logic [2:0]                cfg_idx;
    logic                      cfg_we;

    logic          q_wr, q_rd, q_full, q_empty;
    logic [PW-1:0] q_wdata, q_rdata;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:3];
    assign cfg_we  = psel && penable && pwrite && pready;
    assign prdata  = cfg_reg[cfg_idx];

    // identity matrix
    always_comb
    begin
        cfg_rst                 = '0;
        cfg_rst[REG_COL0_R01]   = ONE;
        cfg_rst[REG_COL1_R01]   = ONE << 32;
        cfg_rst[REG_COL2_R23]   = ONE;
        cfg_rst[REG_TRANSL_R23] = ONE << 32;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= cfg_rst;
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_idx] <= pwdata;
        end
    end

    // front: multiply-accumulate per row and classify w
    hpt_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .point   (point),
        .push    (push),
        .full    (full),
        .q_wr    (q_wr),
        .q_wdata (q_wdata),
        .q_full  (q_full)
    );

    // short queue decouples front and back stalls
    hpt_queue #(
        .W     (PW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .wdata (q_wdata),
        .full  (q_full),
        .rd    (q_rd),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    // back: perspective divide, saturation, output register
    hpt_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_rdata (q_rdata),
        .q_rd    (q_rd),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import hpt_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    // settle time after the last expected result, to cover the full pipeline
    localparam int DRAIN_CYCLES = 80;
    localparam int STALL_LIMIT  = 20000;

    // register indexes not exported by the package
    localparam logic [2:0] REG_COL0_R23   = 3'd1;
    localparam logic [2:0] REG_COL1_R23   = 3'd3;
    localparam logic [2:0] REG_COL2_R01   = 3'd4;
    localparam logic [2:0] REG_TRANSL_R01 = 3'd6;

    logic              clk;
    logic              rst_n;
    point_t            point;
    logic              push;
    logic              full;
    result_t           result;
    logic              empty;
    logic              pop;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [63:0]       pwdata;
    logic [63:0]       prdata;
    logic              pready;

    homogeneous_point_transform_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .point   (point),
        .push    (push),
        .full    (full),
        .result  (result),
        .empty   (empty),
        .pop     (pop),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Transform predictor with its own copy of the matrix registers and a queue
    // of expected results, oldest first.
    class xform_scoreboard;
        logic [63:0] mat_regs [NUM_REGS];
        result_t     pending [$];
        int          errors;

        function new();
            errors = 0;
            load_identity();
        endfunction

        function void load_identity();
            foreach (mat_regs[i])
                mat_regs[i] = '0;
            mat_regs[REG_COL0_R01]   = 64'(1) << FB;
            mat_regs[REG_COL1_R01]   = (64'(1) << FB) << 32;
            mat_regs[REG_COL2_R23]   = 64'(1) << FB;
            mat_regs[REG_TRANSL_R23] = (64'(1) << FB) << 32;
        endfunction

        function void write_reg(int idx, logic [63:0] val);
            if (idx < NUM_REGS)
                mat_regs[idx] = val;
        endfunction

        function logic signed [127:0] coef(int col, int row);
            logic [63:0] r;
            r = mat_regs[col * 2 + row / 2];
            return (row % 2) ? 128'(signed'(r[63:32])) : 128'(signed'(r[31:0]));
        endfunction

        // exact sum of products, floored to FB fraction bits, plus translation
        function logic signed [127:0] row_sum(int row, logic signed [127:0] v [3]);
            logic signed [127:0] acc;
            acc = 0;
            for (int i = 0; i < 3; i++)
                acc += coef(i, row) * v[i];
            return (acc >>> FB) + coef(3, row);
        endfunction

        function logic [31:0] clamp32(logic signed [127:0] v);
            if (v > 128'sd2147483647)
                return 32'h7fff_ffff;
            if (v < -128'sd2147483648)
                return 32'h8000_0000;
            return v[31:0];
        endfunction

        function logic [31:0] fx_quot(logic signed [127:0] num, logic signed [127:0] den);
            logic        neg;
            logic [127:0] un, ud, q;
            neg = (num < 0) != (den < 0);
            un  = (num < 0) ? -num : num;
            ud  = (den < 0) ? -den : den;
            q   = (un << FB) / ud;
            if (q > (128'(1) << 32))
                q = 128'(1) << 32;
            return clamp32(neg ? -$signed(q) : $signed(q));
        endfunction

        function void note_point(point_t p);
            logic signed [127:0] v [3];
            logic signed [127:0] s [4];
            result_t e;
            v[0] = p.point_x;
            v[1] = p.point_y;
            v[2] = p.point_z;
            for (int r = 0; r < 4; r++)
                s[r] = row_sum(r, v);
            if (s[3] != 0)
            begin
                e.result_x = fx_quot(s[0], s[3]);
                e.result_y = fx_quot(s[1], s[3]);
                e.result_z = fx_quot(s[2], s[3]);
                e.divided  = 1'b1;
            end
            else
            begin
                e.result_x = clamp32(s[0]);
                e.result_y = clamp32(s[1]);
                e.result_z = clamp32(s[2]);
                e.divided  = 1'b0;
            end
            pending.push_back(e);
        endfunction

        function void check_result(result_t got);
            result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result beat %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.result_x !== e.result_x)
            begin
                $display("%0t: result_x exp %h got %h", $time, e.result_x, got.result_x);
                errors++;
            end
            if (got.result_y !== e.result_y)
            begin
                $display("%0t: result_y exp %h got %h", $time, e.result_y, got.result_y);
                errors++;
            end
            if (got.result_z !== e.result_z)
            begin
                $display("%0t: result_z exp %h got %h", $time, e.result_z, got.result_z);
                errors++;
            end
            if (got.divided !== e.divided)
            begin
                $display("%0t: divided exp %b got %b", $time, e.divided, got.divided);
                errors++;
            end
        endfunction
    endclass

    xform_scoreboard xform_sb;
    int  hold_cycles;     // receiver hold-off request, counted in the pop process
    int  idle_count;

    // mostly short gaps, now and then long ones
    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55)
            return 0;
        if (k < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // coordinate mix: mostly moderate values, some extremes, some raw bits
    function automatic logic [31:0] rand_coord();
        int k;
        k = $urandom_range(0, 9);
        case (k)
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2, 3: return $urandom();
            default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
        endcase
    endfunction

    function automatic logic [31:0] rand_coef();
        int k;
        k = $urandom_range(0, 9);
        case (k)
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return $urandom();
            default: return 32'($signed($urandom_range(0, 262144)) - 131072);
        endcase
    endfunction

    task automatic cfg_write(input int idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 8);
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        xform_sb.write_reg(idx, val);
        // leave the bus idle between transfers
        @(posedge clk);
    endtask

    // wait for every expected result, then let the pipeline settle
    task automatic wait_drained();
        while (xform_sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_point(input point_t p);
        push  <= 1'b1;
        point <= p;
        do
            @(posedge clk);
        while (full);
        xform_sb.note_point(p);
    endtask

    task automatic send_burst(input int n, input bit gaps);
        point_t p;
        int g;
        for (int i = 0; i < n; i++)
        begin
            p.point_x = rand_coord();
            p.point_y = rand_coord();
            p.point_z = rand_coord();
            send_point(p);
            g = gaps ? gap_len() : 0;
            if (g > 0)
            begin
                push <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
        push <= 1'b0;
    endtask

    // matrix settings: random, perspective (w from z), and w forced to zero
    task automatic load_matrix(input int kind);
        logic [31:0] lo, hi;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            lo = rand_coef();
            hi = rand_coef();
            if (kind == 1 && (i == REG_COL0_R23 || i == REG_COL1_R23
                              || i == REG_TRANSL_R23))
                hi = 32'h0;
            if (kind == 1 && i == REG_COL2_R23)
                hi = 32'h0001_0000;
            if (kind == 2 && i % 2 == 1)
                hi = 32'h0;
            cfg_write(i, {hi, lo});
        end
    endtask

    // result side: random pop stalls plus an optional long hold-off
    initial
    begin
        int g;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                xform_sb.check_result(result);
            if (hold_cycles > 0)
            begin
                pop <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            g = gap_len();
            if (g > 0)
            begin
                pop <= 1'b0;
                repeat (g) @(posedge clk);
            end
            pop <= 1'b1;
        end
    end

    // watchdog: cycles with no accepted beat on any channel
    initial
    begin
        idle_count = 0;
        forever
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty) || (psel && penable))
                idle_count = 0;
            else
                idle_count++;
            if (idle_count >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        point_t p;
        logic [31:0] edge_vals [4];
        xform_sb    = new();
        hold_cycles = 0;
        rst_n   = 1'b0;
        push    = 1'b0;
        point   = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity matrix, extreme coordinates
        edge_vals[0] = 32'h7fff_ffff;
        edge_vals[1] = 32'h8000_0000;
        edge_vals[2] = 32'h0;
        edge_vals[3] = 32'hffff_ffff;
        for (int i = 0; i < 4; i++)
        begin
            p.point_x = edge_vals[i];
            p.point_y = edge_vals[(i + 1) % 4];
            p.point_z = edge_vals[(i + 2) % 4];
            send_point(p);
        end
        push <= 1'b0;
        wait_drained();

        // directed: extreme coefficients saturate, w forced to zero (undivided)
        for (int i = 0; i < NUM_REGS; i++)
            cfg_write(i, (i % 2) ? 64'h0000_0000_7fff_ffff : 64'h8000_0000_7fff_ffff);
        for (int i = 0; i < 4; i++)
        begin
            p.point_x = edge_vals[i];
            p.point_y = edge_vals[3 - i];
            p.point_z = edge_vals[(i + 1) % 4];
            send_point(p);
        end
        push <= 1'b0;
        wait_drained();

        // directed: all-ones registers, w translation of one lsb, z set to one
        for (int i = 0; i < NUM_REGS; i++)
            cfg_write(i, 64'hffff_ffff_ffff_ffff);
        cfg_write(REG_TRANSL_R23, 64'h0000_0001_0000_0000);
        for (int i = 0; i < 6; i++)
        begin
            p.point_x = edge_vals[i % 4];
            p.point_y = rand_coord();
            p.point_z = 32'h0000_0001;
            send_point(p);
        end
        push <= 1'b0;
        wait_drained();

        // random phases over several matrices
        for (int ph = 0; ph < 10; ph++)
        begin
            load_matrix(ph % 3);
            if (ph == 4)
            begin
                // receiver holds off while the sender keeps pushing: fills the queue
                hold_cycles = 300;
                send_burst(100, 1'b0);
            end
            else
                send_burst(115, 1'b1);
            // sender pauses until every expected result has come
            wait_drained();
        end

        wait_drained();
        if (xform_sb.errors == 0 && xform_sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/hpt_pkg.sv
hw/rtl/hpt_queue.sv
hw/rtl/hpt_front.sv
hw/rtl/hpt_back.sv
hw/rtl/homogeneous_point_transform_unit.sv
bench/tb.sv
